// ===== rtl/hwsmd_pkg.sv =====
`default_nettype none

package hwsmd_pkg;

	localparam int MOTOR_BITS    = 21;
	localparam int FORCE_BITS    = 16;
	localparam int GAIN_BITS     = 16;
	localparam int CLEAR_BITS    = 10;
	localparam int MODE_BITS     = 3;
	localparam int FREQ_BITS     = 16;
	localparam int AMP_BITS      = 11;
	localparam int CFG_ADDR_BITS = 3;

	localparam logic [CFG_ADDR_BITS-1:0] CFG_AUTO      = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE      = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_TEST_TGT  = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_CLEARANCE = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_WALL      = 3'd4;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_GAIN      = 3'd5;

	localparam logic [MODE_BITS-1:0] MODE_STOP   = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_TEST   = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_FOLLOW = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_WALL   = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_SPRING = 3'd4;

	localparam int LEFT_EDGE    = -1816;
	localparam int LEFT_TARGET  = -1741;
	localparam int GAP_EMBED    = 7;
	localparam int SPRING_SHIFT = 16;

	localparam logic [FREQ_BITS-1:0] FREQ_MAX   = 16'd43500;
	localparam logic [FREQ_BITS-1:0] FREQ_MIN   = 16'd41500;
	localparam logic [FREQ_BITS-1:0] FREQ_RESET = 16'd42000;
	localparam logic [AMP_BITS-1:0]  AMP_ON     = 11'd2000;

	localparam int CLEAR_RESET = 75;
	localparam int WALL_RESET  = 526;
	localparam int GAIN_RESET  = 4908;

	// gain 1.1112, bias 2046.8, slope 1000/47, dead band 10
	localparam longint GAIN_NUM   = 11112;
	localparam longint GAIN_DEN   = 10000;
	localparam longint BIAS_NUM   = 20468;
	localparam longint BIAS_DEN   = 10;
	localparam longint DEAD_BAND  = 10;
	localparam longint FREQ_DIV   = 47;
	localparam longint FREQ_SCALE = 1000;

	// reciprocal multiply: floor(x/11) for x <= 2^21, floor(x/47) for x < 2^21
	localparam int MUL_BW      = 24;
	localparam int DIV11_MUL   = 6100806;
	localparam int DIV11_SHIFT = 26;
	localparam int QUOT11_BITS = 18;
	localparam int DIV47_MUL   = 2855697;
	localparam int DIV47_SHIFT = 27;
	localparam int DIV47_IN    = 22;

	typedef struct packed {
		logic                 direction;
		logic [FREQ_BITS-1:0] frequency;
		logic [AMP_BITS-1:0]  amplitude;
	} out_item_t;

	function automatic int tgt_w(int cb);
		return ((cb > 16) ? cb : 16) + 2;
	endfunction

	function automatic int err_w(int cb);
		int t;
		t = tgt_w(cb);
		return ((t > 19) ? t : 19) + 1;
	endfunction

	function automatic int mul_aw(int cb, int fb);
		int e;
		int d;
		int m;
		e = err_w(cb) + 1;
		d = fb + 13;
		m = (e > 24) ? e : 24;
		return (m > d) ? m : d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/haptic_wall_spring_motor_drive.sv =====
// channel   direction  fields                               handshake
// in        input      link_count, motor_count, force_req  in_valid / in_stall
// out       output     direction, frequency, amplitude     out_valid / out_stall
// cfg       input      cfg_addr, cfg_wdata                  cfg_wr_en
//
// One transaction at a time through a shared registered multiplier used up to five
// times in series; inside the dead band the result skips S_D, S_M and S_F, stop
// mode goes straight to S_OUT, and manual mode consumes the transaction unanswered.
// Reset is asynchronous; no clearing pass. in_stall is high while a transaction is
// in progress and while a finished result waits on out_stall.
`default_nettype none

module haptic_wall_spring_motor_drive #(
	parameter int COUNT_BITS = 18,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [COUNT_BITS-1:0]           link_count,
	input  wire logic signed [hwsmd_pkg::MOTOR_BITS-1:0] motor_count,
	input  wire logic signed [hwsmd_pkg::FORCE_BITS-1:0] force_req,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        direction,
	output logic [hwsmd_pkg::FREQ_BITS-1:0]             frequency,
	output logic [hwsmd_pkg::AMP_BITS-1:0]              amplitude,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [hwsmd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
	input  wire logic [((COUNT_BITS > 16) ? COUNT_BITS : 16)-1:0] cfg_wdata
);
	import hwsmd_pkg::*;

	localparam int CDW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int MUL_AW = mul_aw(COUNT_BITS, FRAC_BITS);

	logic                         auto_enable;
	logic [MODE_BITS-1:0]         work_mode;
	logic signed [COUNT_BITS-1:0] test_target;
	logic [CLEAR_BITS-1:0]        clearance;
	logic signed [COUNT_BITS-1:0] wall_position;
	logic [GAIN_BITS-1:0]         spring_gain;
	logic signed [MUL_AW-1:0]     mul_a;
	logic signed [MUL_BW-1:0]     mul_b;
	logic signed [MUL_AW+MUL_BW-1:0] mul_p;
	out_item_t                    out_item;

	hwsmd_cfg #(
		.COUNT_BITS (COUNT_BITS),
		.DW         (CDW)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.auto_enable_q   (auto_enable),
		.work_mode_q     (work_mode),
		.test_target_q   (test_target),
		.clearance_q     (clearance),
		.wall_position_q (wall_position),
		.spring_gain_q   (spring_gain)
	);

	hwsmd_mul #(
		.AW (MUL_AW),
		.BW (MUL_BW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	hwsmd_seq #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.MUL_AW     (MUL_AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.link_count    (link_count),
		.motor_count   (motor_count),
		.force_req     (force_req),
		.auto_enable   (auto_enable),
		.work_mode     (work_mode),
		.test_target   (test_target),
		.clearance     (clearance),
		.wall_position (wall_position),
		.spring_gain   (spring_gain),
		.mul_a         (mul_a),
		.mul_b         (mul_b),
		.mul_p         (mul_p),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_item      (out_item)
	);

	assign direction = out_item.direction;
	assign frequency = out_item.frequency;
	assign amplitude = out_item.amplitude;

endmodule

`default_nettype wire

// ===== rtl/hwsmd_mul.sv =====
`default_nettype none

module hwsmd_mul #(
	parameter int AW = 24,
	parameter int BW = 24
) (
	input  wire logic                 clk,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

// ===== rtl/hwsmd_cfg.sv =====
`default_nettype none

module hwsmd_cfg #(
	parameter int COUNT_BITS = 18,
	parameter int DW         = 18
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [hwsmd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  wire logic [DW-1:0]                         cfg_wdata,
	output logic                                       auto_enable_q,
	output logic [hwsmd_pkg::MODE_BITS-1:0]            work_mode_q,
	output logic signed [COUNT_BITS-1:0]               test_target_q,
	output logic [hwsmd_pkg::CLEAR_BITS-1:0]           clearance_q,
	output logic signed [COUNT_BITS-1:0]               wall_position_q,
	output logic [hwsmd_pkg::GAIN_BITS-1:0]            spring_gain_q
);
	import hwsmd_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q   <= 1'b0;
			work_mode_q     <= MODE_STOP;
			test_target_q   <= '0;
			clearance_q     <= CLEAR_BITS'(CLEAR_RESET);
			wall_position_q <= COUNT_BITS'(WALL_RESET);
			spring_gain_q   <= GAIN_BITS'(GAIN_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_AUTO:      auto_enable_q   <= cfg_wdata[0];
				CFG_MODE:      work_mode_q     <= cfg_wdata[MODE_BITS-1:0];
				CFG_TEST_TGT:  test_target_q   <= $signed(cfg_wdata[COUNT_BITS-1:0]);
				CFG_CLEARANCE: clearance_q     <= cfg_wdata[CLEAR_BITS-1:0];
				CFG_WALL:      wall_position_q <= $signed(cfg_wdata[COUNT_BITS-1:0]);
				CFG_GAIN:      spring_gain_q   <= cfg_wdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hwsmd_seq.sv =====
`default_nettype none

module hwsmd_seq #(
	parameter int COUNT_BITS = 18,
	parameter int FRAC_BITS  = 8,
	parameter int MUL_AW     = 24
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         in_valid,
	output logic                                              in_stall,
	input  wire logic signed [COUNT_BITS-1:0]                 link_count,
	input  wire logic signed [hwsmd_pkg::MOTOR_BITS-1:0]      motor_count,
	input  wire logic signed [hwsmd_pkg::FORCE_BITS-1:0]      force_req,
	input  wire logic                                         auto_enable,
	input  wire logic [hwsmd_pkg::MODE_BITS-1:0]              work_mode,
	input  wire logic signed [COUNT_BITS-1:0]                 test_target,
	input  wire logic [hwsmd_pkg::CLEAR_BITS-1:0]             clearance,
	input  wire logic signed [COUNT_BITS-1:0]                 wall_position,
	input  wire logic [hwsmd_pkg::GAIN_BITS-1:0]              spring_gain,
	output logic signed [MUL_AW-1:0]                          mul_a,
	output logic signed [hwsmd_pkg::MUL_BW-1:0]               mul_b,
	input  wire logic signed [MUL_AW+hwsmd_pkg::MUL_BW-1:0]   mul_p,
	output logic                                              out_valid,
	input  wire logic                                         out_stall,
	output hwsmd_pkg::out_item_t                              out_item
);
	import hwsmd_pkg::*;

	localparam int TW = tgt_w(COUNT_BITS);
	localparam int EW = err_w(COUNT_BITS);
	localparam int PW = MUL_AW + MUL_BW;
	localparam int SW = COUNT_BITS + 18;
	localparam int CW = COUNT_BITS + 1;
	localparam int DW = FRAC_BITS + 11;

	localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
	localparam longint GAIN_Q = (GAIN_NUM * ONE_Q + GAIN_DEN / 2) / GAIN_DEN;
	localparam longint BIAS_Q = (BIAS_NUM * ONE_Q + BIAS_DEN / 2) / BIAS_DEN;
	localparam longint DEAD_Q = DEAD_BAND * ONE_Q;
	localparam longint T_HI   = longint'(FREQ_MAX) * FREQ_DIV * ONE_Q;
	localparam longint T_LO   = longint'(FREQ_MIN) * FREQ_DIV * ONE_Q;

	localparam logic [PW-1:0] BIAS_C = PW'(BIAS_Q);
	localparam logic [PW-1:0] DEAD_C = PW'(DEAD_Q);
	localparam logic [PW-1:0] T_HI_C = PW'(T_HI);
	localparam logic [PW-1:0] T_LO_C = PW'(T_LO);

	typedef enum logic [3:0] {
		S_IDLE, S_POS, S_SPR, S_TGT, S_ERR, S_MULE, S_MAG, S_D, S_M, S_F, S_OUT
	} state_t;

	state_t                      state_q;
	logic signed [COUNT_BITS-1:0] link_q;
	logic signed [FORCE_BITS-1:0] force_q;
	logic [MOTOR_BITS:0]          m2_q;
	logic                         mneg_q;
	logic signed [QUOT11_BITS:0]  mpos_q;
	logic                         lt_left_q;
	logic                         lt_free_q;
	logic                         lt_wall_q;
	logic signed [TW-1:0]         target_q;
	logic signed [TW-1:0]         last_q;
	logic [EW-1:0]                abs_q;
	logic                         dir_q;
	logic                         neg_q;
	logic [DW-1:0]                d_q;
	logic                         hi_q;
	logic                         lo_q;
	logic [FREQ_BITS-1:0]         held_q;
	out_item_t                    res_q;
	out_item_t                    out_q;
	logic                         out_valid_q;

	logic                         out_free;
	logic [MOTOR_BITS:0]          m_ext;
	logic [MOTOR_BITS:0]          m_abs;
	logic [QUOT11_BITS:0]         mq;
	logic signed [CW-1:0]         free_edge;
	logic signed [SW-1:0]         spr_sum;
	logic signed [SW-1:0]         spr_rnd;
	logic signed [TW-1:0]         tgt_follow;
	logic signed [TW-1:0]         tgt_c;
	logic signed [EW-1:0]         err_c;
	logic [PW-1:0]                mag_c;
	logic [FREQ_BITS-1:0]         f_c;

	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign m_ext     = {motor_count[MOTOR_BITS-1], motor_count};
	assign m_abs     = motor_count[MOTOR_BITS-1] ? -m_ext : m_ext;
	assign mq        = {1'b0, mul_p[DIV11_SHIFT +: QUOT11_BITS]};
	assign free_edge = CW'(wall_position) - CW'($signed({1'b0, clearance}));
	assign spr_sum   = (SW'(wall_position) <<< SPRING_SHIFT) + SW'(mul_p);
	assign spr_rnd   = spr_sum + (spr_sum[SW-1] ? SW'((1 << SPRING_SHIFT) - 1) : SW'(0));
	assign tgt_follow = TW'(link_q) + TW'($signed({1'b0, clearance}));
	assign err_c     = EW'(target_q) - EW'(mpos_q);
	assign mag_c     = $unsigned(mul_p);

	always_comb begin
		case (work_mode) inside
			MODE_TEST:   tgt_c = TW'(test_target);
			MODE_FOLLOW: tgt_c = tgt_follow;
			MODE_WALL, MODE_SPRING: begin
				if (lt_left_q)
					tgt_c = TW'(LEFT_TARGET);
				else if (lt_free_q)
					tgt_c = tgt_follow;
				else if (work_mode == MODE_WALL)
					tgt_c = TW'(wall_position);
				else if (lt_wall_q)
					tgt_c = TW'(wall_position) + TW'(GAP_EMBED);
				else
					tgt_c = TW'(spr_rnd >>> SPRING_SHIFT);
			end
			default: tgt_c = last_q;
		endcase
	end

	always_comb begin
		if (hi_q)
			f_c = FREQ_MAX;
		else if (lo_q)
			f_c = FREQ_MIN;
		else
			f_c = mul_p[DIV47_SHIFT +: FREQ_BITS];
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_POS: begin
				mul_a = MUL_AW'($signed({1'b0, m2_q}));
				mul_b = MUL_BW'(DIV11_MUL);
			end
			S_SPR: begin
				mul_a = MUL_AW'(force_q);
				mul_b = MUL_BW'($signed({1'b0, spring_gain}));
			end
			S_MULE: begin
				mul_a = MUL_AW'($signed({1'b0, abs_q}));
				mul_b = MUL_BW'(GAIN_Q);
			end
			S_D: begin
				mul_a = MUL_AW'($signed({1'b0, d_q}));
				mul_b = MUL_BW'(FREQ_SCALE);
			end
			S_M: begin
				mul_a = MUL_AW'($signed({1'b0, mul_p[FRAC_BITS +: DIV47_IN]}));
				mul_b = MUL_BW'(DIV47_MUL);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			held_q      <= FREQ_RESET;
			last_q      <= '0;
			link_q      <= '0;
			force_q     <= '0;
			m2_q        <= '0;
			mneg_q      <= 1'b0;
			mpos_q      <= '0;
			lt_left_q   <= 1'b0;
			lt_free_q   <= 1'b0;
			lt_wall_q   <= 1'b0;
			target_q    <= '0;
			abs_q       <= '0;
			dir_q       <= 1'b0;
			neg_q       <= 1'b0;
			d_q         <= '0;
			hi_q        <= 1'b0;
			lo_q        <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && auto_enable) begin
						if (work_mode == MODE_STOP) begin
							res_q   <= '{direction: 1'b0, frequency: FREQ_MIN, amplitude: '0};
							state_q <= S_OUT;
						end else begin
							link_q  <= link_count;
							force_q <= force_req;
							m2_q    <= {m_abs[MOTOR_BITS-1:0], 1'b0};
							mneg_q  <= motor_count[MOTOR_BITS-1];
							state_q <= S_POS;
						end
					end
				end
				S_POS: state_q <= S_SPR;
				S_SPR: begin
					mpos_q    <= mneg_q ? -$signed(mq) : $signed(mq);
					lt_left_q <= CW'(link_q) < CW'(LEFT_EDGE);
					lt_free_q <= CW'(link_q) < free_edge;
					lt_wall_q <= link_q < wall_position;
					state_q   <= S_TGT;
				end
				S_TGT: begin
					target_q <= tgt_c;
					last_q   <= tgt_c;
					state_q  <= S_ERR;
				end
				S_ERR: begin
					abs_q   <= err_c[EW-1] ? $unsigned(-err_c) : $unsigned(err_c);
					dir_q   <= !err_c[EW-1] && (err_c != '0);
					state_q <= S_MULE;
				end
				S_MULE: state_q <= S_MAG;
				S_MAG: begin
					if (mag_c > DEAD_C) begin
						neg_q   <= mag_c > BIAS_C;
						d_q     <= DW'(BIAS_C - mag_c);
						state_q <= S_D;
					end else begin
						res_q   <= '{direction: dir_q, frequency: held_q, amplitude: '0};
						state_q <= S_OUT;
					end
				end
				S_D: state_q <= S_M;
				S_M: begin
					hi_q    <= !neg_q && (mag_c >= T_HI_C);
					lo_q    <= neg_q || (mag_c < T_LO_C);
					state_q <= S_F;
				end
				S_F: begin
					held_q  <= f_c;
					res_q   <= '{direction: dir_q, frequency: f_c, amplitude: AMP_ON};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.frequency >= FREQ_MIN) && (out_q.frequency <= FREQ_MAX))
		else $error("frequency out of range");

	a_out_amp_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.amplitude != '0)) |-> (out_q.amplitude == AMP_ON))
		else $error("bad amplitude");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q >= FREQ_MIN) && (held_q <= FREQ_MAX))
		else $error("held frequency out of range");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_OUT) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("result not loaded");

	a_manual_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !auto_enable) |=> ((state_q == S_IDLE) && !$rose(out_valid_q)))
		else $error("manual mode produced work");

endmodule

`default_nettype wire

// ===== dv/hwsmd_drive_checker.sv =====
`timescale 1ns / 100ps

module hwsmd_drive_checker #(
	parameter int COUNT_BITS = 18,
	parameter int FRAC_BITS  = 8,
	parameter int CFG_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_stall,
	input  logic signed [COUNT_BITS-1:0]             link_count,
	input  logic signed [hwsmd_pkg::MOTOR_BITS-1:0]  motor_count,
	input  logic signed [hwsmd_pkg::FORCE_BITS-1:0]  force_req,
	input  logic                                     out_valid,
	input  logic                                     out_stall,
	input  logic                                     direction,
	input  logic [hwsmd_pkg::FREQ_BITS-1:0]          frequency,
	input  logic [hwsmd_pkg::AMP_BITS-1:0]           amplitude,
	input  logic                                     cfg_wr_en,
	input  logic [hwsmd_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
	input  logic [CFG_W-1:0]                         cfg_wdata,
	output int                                       bad_drive_cnt,
	output int                                       drive_backlog
);
	import hwsmd_pkg::*;

	localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
	localparam longint GAIN_Q    = (GAIN_NUM * ONE_Q + GAIN_DEN / 2) / GAIN_DEN;
	localparam longint BIAS_Q    = (BIAS_NUM * ONE_Q + BIAS_DEN / 2) / BIAS_DEN;
	localparam longint DEAD_Q    = DEAD_BAND * ONE_Q;
	localparam longint SLOPE_DIV = FREQ_DIV * ONE_Q;

	bit                   en_q;
	logic [MODE_BITS-1:0] mode_q;
	longint               test_q, clear_q, wall_q, gain_q;
	longint               held_q, last_q;
	out_item_t            drive_fifo[$];
	int                   errs = 0;

	// one control tick; returns 0 when the tick produces no drive command
	function automatic bit compute_drive(input longint lk, input longint mc, input longint fr,
			output out_item_t d);
		longint mpos, tgt, err, spd, mag, f;
		d = '0;
		if (!en_q)
			return 1'b0;
		if (mode_q == MODE_STOP) begin
			d.frequency = FREQ_MIN;
			return 1'b1;
		end
		mpos = (mc * 2) / 11;
		tgt = last_q;
		case (mode_q)
			MODE_TEST: tgt = test_q;
			MODE_FOLLOW: tgt = lk + clear_q;
			MODE_WALL, MODE_SPRING: begin
				if (lk < LEFT_EDGE)
					tgt = LEFT_TARGET;
				else if (lk < wall_q - clear_q)
					tgt = lk + clear_q;
				else if (mode_q == MODE_WALL)
					tgt = wall_q;
				else if (lk < wall_q)
					tgt = wall_q + GAP_EMBED;
				else
					tgt = (wall_q * 65536 + fr * gain_q) / 65536;
			end
			default: ;
		endcase
		last_q = tgt;
		err = tgt - mpos;
		spd = err * GAIN_Q;
		mag = (spd < 0) ? -spd : spd;
		if (mag > DEAD_Q) begin
			f = ((BIAS_Q - mag) * FREQ_SCALE) / SLOPE_DIV;
			d.amplitude = AMP_ON;
		end else begin
			f = held_q;
		end
		if (f > longint'(FREQ_MAX))
			f = FREQ_MAX;
		else if (f < longint'(FREQ_MIN))
			f = FREQ_MIN;
		held_q = f;
		d.frequency = f[FREQ_BITS-1:0];
		d.direction = (spd > 0);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : mon
		out_item_t cmd, want, got;
		if (!arst_n) begin
			en_q = 1'b0;
			mode_q = MODE_STOP;
			test_q = 0;
			clear_q = CLEAR_RESET;
			wall_q = WALL_RESET;
			gain_q = GAIN_RESET;
			held_q = FREQ_RESET;
			last_q = 0;
			drive_fifo.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					CFG_AUTO: en_q = cfg_wdata[0];
					CFG_MODE: mode_q = cfg_wdata[MODE_BITS-1:0];
					CFG_TEST_TGT: test_q = $signed(cfg_wdata[COUNT_BITS-1:0]);
					CFG_CLEARANCE: clear_q = cfg_wdata[CLEAR_BITS-1:0];
					CFG_WALL: wall_q = $signed(cfg_wdata[COUNT_BITS-1:0]);
					CFG_GAIN: gain_q = cfg_wdata[GAIN_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (compute_drive(link_count, motor_count, force_req, cmd))
					drive_fifo.push_back(cmd);
			end
			if (out_valid && !out_stall) begin
				got = {direction, frequency, amplitude};
				if (drive_fifo.size() == 0) begin
					errs++;
					$display("%0t: drive command with none pending, actual dir %0d freq %0d amp %0d",
						$time, got.direction, got.frequency, got.amplitude);
				end else begin
					want = drive_fifo.pop_front();
					if (got.direction !== want.direction) begin
						errs++;
						$display("%0t: direction mismatch, expected %0d, actual %0d",
							$time, want.direction, got.direction);
					end
					if (got.frequency !== want.frequency) begin
						errs++;
						$display("%0t: frequency mismatch, expected %0d, actual %0d",
							$time, want.frequency, got.frequency);
					end
					if (got.amplitude !== want.amplitude) begin
						errs++;
						$display("%0t: amplitude mismatch, expected %0d, actual %0d",
							$time, want.amplitude, got.amplitude);
					end
				end
			end
		end
		bad_drive_cnt <= errs;
		drive_backlog <= drive_fifo.size();
	end

endmodule

// ===== dv/tb_haptic_wall_spring_motor_drive.sv =====
`timescale 1ns / 100ps

module tb_haptic_wall_spring_motor_drive;
	import hwsmd_pkg::*;

	localparam int COUNT_BITS = 18;
	localparam int CFG_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int TICKS      = 1650;
	localparam int LIMIT      = 1000000;

	localparam logic [MODE_BITS-1:0] MODE_SPARE5 = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_BITS-1:0] MODE_SPARE7 = 3'd7;

	localparam longint LINK_MIN  = -131072;
	localparam longint LINK_MAX  = 131071;
	localparam longint MOTOR_MIN = -1048576;
	localparam longint MOTOR_MAX = 1048575;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic signed [COUNT_BITS-1:0] link_count = '0;
	logic signed [MOTOR_BITS-1:0] motor_count = '0;
	logic signed [FORCE_BITS-1:0] force_req = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         direction;
	logic [FREQ_BITS-1:0]         frequency;
	logic [AMP_BITS-1:0]          amplitude;
	logic                         cfg_wr_en = 1'b0;
	logic [CFG_ADDR_BITS-1:0]     cfg_addr = '0;
	logic [CFG_W-1:0]             cfg_wdata = '0;

	int bad_drive_cnt;
	int drive_backlog;

	int tx_pct = 14;
	int rx_pct = 72;
	int live = 0;

	bit                   cur_auto;
	logic [MODE_BITS-1:0] cur_mode;
	longint               cur_tt, cur_clr, cur_wall, cur_gain;
	longint               last_aim = 0;

	haptic_wall_spring_motor_drive #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.link_count(link_count), .motor_count(motor_count), .force_req(force_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.direction(direction), .frequency(frequency), .amplitude(amplitude),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	hwsmd_drive_checker #(.COUNT_BITS(COUNT_BITS)) drive_mon (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.link_count(link_count), .motor_count(motor_count), .force_req(force_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.direction(direction), .frequency(frequency), .amplitude(amplitude),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.bad_drive_cnt(bad_drive_cnt), .drive_backlog(drive_backlog)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= (int'($urandom_range(99)) < rx_pct);
	end

	function automatic longint clampv(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic cfg_put(input logic [CFG_ADDR_BITS-1:0] a, input longint v);
		cfg_wr_en <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v[CFG_W-1:0];
		@(posedge clk);
	endtask

	// drain the block, then rewrite every register
	task automatic configure(input bit en, input logic [MODE_BITS-1:0] md, input longint tt,
			input longint clr, input longint wl, input longint gn);
		in_valid <= 1'b0;
		@(posedge clk);
		while (drive_backlog != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		cfg_put(CFG_AUTO, en);
		cfg_put(CFG_MODE, md);
		cfg_put(CFG_TEST_TGT, tt);
		cfg_put(CFG_CLEARANCE, clr);
		cfg_put(CFG_WALL, wl);
		cfg_put(CFG_GAIN, gn);
		cfg_wr_en <= 1'b0;
		cur_auto = en;
		cur_mode = md;
		cur_tt = tt;
		cur_clr = clr;
		cur_wall = wl;
		cur_gain = gn;
	endtask

	task automatic send(input longint lk, input longint mc, input longint fr);
		if (live < TICKS / 3) begin
			tx_pct = 14;
			rx_pct = 72;
		end else if (live < 2 * TICKS / 3) begin
			tx_pct = 72;
			rx_pct = 14;
		end else begin
			tx_pct = 0;
			rx_pct = 0;
		end
		while (int'($urandom_range(99)) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		link_count <= lk[COUNT_BITS-1:0];
		motor_count <= mc[MOTOR_BITS-1:0];
		force_req <= fr[FORCE_BITS-1:0];
		do
			@(posedge clk);
		while (in_stall);
		if (cur_auto)
			live++;
	endtask

	// link near the region edges, motor near the rough target so the dead band,
	// the linear range and both clamps all get hit
	task automatic rand_item();
		longint lk, fr, mc, tgt;
		int r;
		r = $urandom_range(9);
		if (r == 0)
			lk = $signed(COUNT_BITS'($urandom));
		else if (r == 1)
			lk = LEFT_EDGE + int'($urandom_range(6)) - 3;
		else if (r < 4)
			lk = cur_wall - cur_clr + int'($urandom_range(6)) - 3;
		else if (r < 6)
			lk = cur_wall + int'($urandom_range(6)) - 3;
		else
			lk = cur_wall + int'($urandom_range(4000)) - 2000;
		lk = clampv(lk, LINK_MIN, LINK_MAX);
		r = $urandom_range(9);
		if (r == 0)
			fr = 32767;
		else if (r == 1)
			fr = -32768;
		else if (r < 6)
			fr = $signed(16'($urandom));
		else
			fr = int'($urandom_range(4096)) - 2048;
		case (cur_mode)
			MODE_TEST: tgt = cur_tt;
			MODE_FOLLOW: tgt = lk + cur_clr;
			MODE_WALL, MODE_SPRING: begin
				if (lk < LEFT_EDGE)
					tgt = LEFT_TARGET;
				else if (lk < cur_wall - cur_clr)
					tgt = lk + cur_clr;
				else if (cur_mode == MODE_WALL)
					tgt = cur_wall;
				else if (lk < cur_wall)
					tgt = cur_wall + GAP_EMBED;
				else
					tgt = cur_wall + ((fr * cur_gain) >>> 16);
			end
			default: tgt = last_aim;
		endcase
		if (cur_mode != MODE_STOP)
			last_aim = tgt;
		r = $urandom_range(9);
		if (r == 0) begin
			mc = $signed(MOTOR_BITS'($urandom));
		end else begin
			if (r < 3)
				tgt = tgt + int'($urandom_range(18)) - 9;
			else if (r < 8)
				tgt = tgt + int'($urandom_range(200)) - 100;
			else
				tgt = tgt + int'($urandom_range(6000)) - 3000;
			mc = clampv(tgt * 11 / 2 + int'($urandom_range(4)) - 2, MOTOR_MIN, MOTOR_MAX);
		end
		send(lk, mc, fr);
	endtask

	initial begin : stim
		int p, n, k;
		bit en;
		logic [MODE_BITS-1:0] md;
		longint tt, clr, wl, gn;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(1'b0, MODE_STOP, 0, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(0, 0, 0);
		send(LINK_MIN, MOTOR_MAX, -32768);
		configure(1'b1, MODE_STOP, 0, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(LINK_MAX, MOTOR_MIN, 32767);
		configure(1'b1, MODE_TEST, LINK_MAX, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(0, MOTOR_MIN, 0);
		send(0, 0, 0);
		configure(1'b1, MODE_TEST, LINK_MIN, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(0, MOTOR_MAX, 0);
		configure(1'b1, MODE_TEST, 0, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(0, 0, 0);
		send(0, 55, 0);
		send(0, 11, 0);
		configure(1'b1, MODE_FOLLOW, 0, 1023, WALL_RESET, GAIN_RESET);
		send(LINK_MAX, 0, 0);
		send(LINK_MIN, 0, 0);
		configure(1'b1, MODE_WALL, 0, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(LEFT_EDGE - 1, -9576, 0);
		send(LEFT_EDGE, 0, 0);
		send(450, 3300, 0);
		send(451, 2893, 0);
		send(600, 0, 0);
		configure(1'b1, MODE_SPRING, 0, CLEAR_RESET, WALL_RESET, 65535);
		send(500, 0, 0);
		send(WALL_RESET, 0, 32767);
		send(WALL_RESET, 0, -32768);
		send(LINK_MAX, MOTOR_MAX, 256);
		configure(1'b1, MODE_SPARE5, 0, CLEAR_RESET, WALL_RESET, GAIN_RESET);
		send(0, 0, 0);

		p = 0;
		while (live < TICKS) begin
			en = (p % 13 != 12);
			case (p % 11)
				0: md = MODE_TEST;
				1: md = MODE_FOLLOW;
				2, 4: md = MODE_WALL;
				3, 5, 8: md = MODE_SPRING;
				6: md = MODE_STOP;
				7: md = MODE_SPARE5;
				9: md = MODE_SPARE6;
				default: md = MODE_SPARE7;
			endcase
			case (p % 6)
				0: begin
					tt = LINK_MIN;
					clr = 0;
					wl = LINK_MIN;
					gn = 0;
				end
				1: begin
					tt = LINK_MAX;
					clr = 1023;
					wl = LINK_MAX;
					gn = 65535;
				end
				default: begin
					tt = int'($urandom_range(6000)) - 3000;
					clr = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(300);
					wl = int'($urandom_range(5000)) - 2500;
					gn = $urandom_range(65535);
				end
			endcase
			configure(en, md, tt, clr, wl, gn);
			n = en ? 30 + $urandom_range(40) : 6;
			for (k = 0; k < n; k++)
				rand_item();
			p++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (drive_backlog != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (bad_drive_cnt == 0 && drive_backlog == 0)
			$display("tb_haptic_wall_spring_motor_drive passed");
		else
			$display("tb_haptic_wall_spring_motor_drive failed");
		$finish;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_haptic_wall_spring_motor_drive failed");
		$finish;
	end

endmodule
